[rtl/core/esh_pkg.sv]
package esh_pkg;

    localparam int DATA_W = 24;
    localparam int CHAN_FIELD_W = 10;
    localparam int COUNT_W = 32;
    localparam int DIV_STEPS = DATA_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_READ_CLEAR = 2'd2;

    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_READ_DONE = 3'd4;

    localparam logic [1:0] REG_E_HIGH = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] REG_NUM_CHANNELS = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0]
    {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic
    {
        B_IDLE,
        B_EXEC
    } back_state_t;

    typedef enum logic [1:0]
    {
        OP_PASS,
        OP_COUNT,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] e_high;
        logic [DATA_W-1:0] bin_width;
        logic [CHAN_FIELD_W-1:0] num_channels;
    } cfg_t;

    typedef struct packed
    {
        op_t op;
        logic [2:0] status;
        logic [CHAN_FIELD_W-1:0] bin;
        logic [3:0] det;
        logic cry;
    } cmd_t;

endpackage

[rtl/core/esh_front.sv]
module esh_front
    import esh_pkg::*;
#(
    parameter int DETECTORS = 16,
    parameter int CHANNELS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic clear_done,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0] s_tuser,
    output logic q_push,
    input  logic q_full,
    output cmd_t q_cmd
);

    front_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] func_reg;
    logic [3:0] det_reg;
    logic [DATA_W-1:0] energy_reg;
    logic [1:0] cry_reg;
    logic [CHAN_FIELD_W-1:0] bidx_reg;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;

    logic accept;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W:0] rem_sh;
    logic ge;
    logic [CHAN_FIELD_W-1:0] ch;

    assign s_tready = (state_reg == F_IDLE) && clear_done;
    assign accept = s_tvalid && s_tready;
    assign divisor = (cfg.bin_width == '0) ? DATA_W'(1) : cfg.bin_width;

    // One restoring division step per cycle: quotient bits shift in at the bottom of quo_reg.
    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign ge = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            det_reg <= s_tdata[3:0];
            energy_reg <= s_tdata[27:4];
            cry_reg <= s_tdata[29:28];
            bidx_reg <= s_tdata[39:30];
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        q_push = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    rem_next = '0;
                    quo_next = cfg.e_high - s_tdata[27:4];
                    cnt_next = '0;
                    state_next = (s_tuser == FUNC_RECORD) ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                rem_next = ge ? DATA_W'(rem_sh - {1'b0, divisor}) : rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign ch = cfg.num_channels - quo_reg[CHAN_FIELD_W-1:0];

    always_comb
    begin
        q_cmd.op = OP_PASS;
        q_cmd.status = ST_IGNORED;
        q_cmd.bin = '0;
        q_cmd.det = det_reg;
        q_cmd.cry = cry_reg[0];
        if (func_reg == 2'd3)
        begin
            q_cmd.status = ST_IGNORED;
        end
        else if ((32'(det_reg) >= DETECTORS) || (cry_reg > 2'd1))
        begin
            q_cmd.status = ST_BAD_ADDR;
        end
        else if (func_reg == FUNC_RECORD)
        begin
            if (energy_reg == '0)
            begin
                q_cmd.status = ST_IGNORED;
            end
            else if (energy_reg > cfg.e_high)
            begin
                q_cmd.status = ST_RANGE;
            end
            else if (quo_reg >= DATA_W'(cfg.num_channels))
            begin
                q_cmd.status = ST_IGNORED;
            end
            else if (32'(ch) >= CHANNELS)
            begin
                q_cmd.status = ST_RANGE;
            end
            else
            begin
                q_cmd.op = OP_COUNT;
                q_cmd.status = ST_COUNTED;
                q_cmd.bin = ch;
            end
        end
        else if (32'(bidx_reg) >= CHANNELS)
        begin
            q_cmd.status = ST_RANGE;
            q_cmd.bin = bidx_reg;
        end
        else
        begin
            q_cmd.op = (func_reg == FUNC_READ_CLEAR) ? OP_CLEAR : OP_READ;
            q_cmd.status = ST_READ_DONE;
            q_cmd.bin = bidx_reg;
        end
    end

endmodule

[rtl/core/esh_queue.sv]
module esh_queue
    import esh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0] fill_reg;

    assign full = (fill_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10: fill_reg <= fill_reg + 1'b1;
                2'b01: fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/esh_back.sv]
module esh_back
    import esh_pkg::*;
#(
    parameter int DETECTORS = 16,
    parameter int CHANNELS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    output logic clear_done,
    input  logic q_empty,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [47:0] m_tdata,
    output logic [2:0] m_tuser
);

    localparam int DET_W = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int CH_W = $clog2(CHANNELS);
    localparam int ADDR_W = DET_W + 1 + CH_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    logic [COUNT_W-1:0] mem [MEM_DEPTH];

    back_state_t state_reg, state_next;
    logic [ADDR_W:0] clr_cnt_reg;
    cmd_t cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic out_valid_reg;
    logic [2:0] out_status_reg;
    logic [CHAN_FIELD_W-1:0] out_bin_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [31:0] addr_full;
    logic [ADDR_W-1:0] rd_addr;
    logic exec;
    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] inc_count;
    logic [COUNT_W-1:0] res_count;

    assign clear_done = clr_cnt_reg[ADDR_W];

    assign addr_full = (((32'(q_cmd.det) << 1) | 32'(q_cmd.cry)) << CH_W) | 32'(q_cmd.bin);
    assign rd_addr = addr_full[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        exec = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                // The result register must be free by the time this command executes.
                if (clear_done && !q_empty && (!out_valid_reg || m_tready))
                begin
                    q_pop = 1'b1;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                exec = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign inc_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        res_count = '0;
        if (!clear_done)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_cnt_reg[ADDR_W-1:0];
        end
        else if (exec)
        begin
            case (cmd_reg.op)
                OP_COUNT:
                begin
                    mem_we = 1'b1;
                    mem_wdata = inc_count;
                    res_count = inc_count;
                end
                OP_READ:
                begin
                    res_count = rd_data_reg;
                end
                OP_CLEAR:
                begin
                    mem_we = 1'b1;
                    res_count = rd_data_reg;
                end
                default:
                begin
                    res_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (!clear_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            addr_reg <= rd_addr;
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (exec)
        begin
            out_status_reg <= cmd_reg.status;
            out_bin_reg <= cmd_reg.bin;
            out_count_reg <= res_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_status_reg;
    assign m_tdata = {6'd0, out_count_reg, out_bin_reg};

endmodule

[rtl/core/energy_spectrum_histogrammer.sv]
// A record beat runs through the bit-serial divider and is then pushed into the command queue; a
// read beat goes straight to the queue. The back end pops each command, updates its counter when
// it counts or clears, and registers the result. No new beat is taken until the last is queued.
// Reset is asynchronous and active low. After reset the counter memory is swept to zero, one
// bin per cycle over all 2**(clog2(DETECTORS)+1+clog2(CHANNELS)) bins, 32768 with the defaults;
// no beat is taken during the sweep, while register writes are.
module energy_spectrum_histogrammer
    import esh_pkg::*;
#(
    parameter int DETECTORS = 16,
    parameter int CHANNELS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [39:0] s_tdata,   // detector[3:0], energy[27:4], crystal[29:28], bin_index[39:30]
    input  logic [1:0] s_tuser,    // func[1:0]
    output logic m_tvalid,
    input  logic m_tready,
    output logic [47:0] m_tdata,   // bin_out[9:0], count[41:10], zero fill[47:42]
    output logic [2:0] m_tuser     // status[2:0]
);

    logic [DATA_W-1:0] e_high_reg;
    logic [DATA_W-1:0] bin_width_reg;
    logic [CHAN_FIELD_W-1:0] num_channels_reg;
    cfg_t cfg;
    logic cfg_wr;
    logic clear_done;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_high_reg <= 24'hFFFFFF;
            bin_width_reg <= 24'd16384;
            num_channels_reg <= 10'd1023;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_E_HIGH: e_high_reg <= pwdata[DATA_W-1:0];
                REG_BIN_WIDTH: bin_width_reg <= pwdata[DATA_W-1:0];
                REG_NUM_CHANNELS: num_channels_reg <= pwdata[CHAN_FIELD_W-1:0];
                default: e_high_reg <= e_high_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_E_HIGH: prdata = 32'(e_high_reg);
            REG_BIN_WIDTH: prdata = 32'(bin_width_reg);
            REG_NUM_CHANNELS: prdata = 32'(num_channels_reg);
            default: prdata = '0;
        endcase
    end

    assign cfg.e_high = e_high_reg;
    assign cfg.bin_width = bin_width_reg;
    assign cfg.num_channels = num_channels_reg;

    esh_front #(
        .DETECTORS(DETECTORS),
        .CHANNELS(CHANNELS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .clear_done(clear_done),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .q_push(q_push),
        .q_full(q_full),
        .q_cmd(push_cmd)
    );

    esh_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(push_cmd),
        .full(q_full),
        .pop(q_pop),
        .pop_data(pop_cmd),
        .empty(q_empty)
    );

    esh_back #(
        .DETECTORS(DETECTORS),
        .CHANNELS(CHANNELS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .clear_done(clear_done),
        .q_empty(q_empty),
        .q_cmd(pop_cmd),
        .q_pop(q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule

[rtl/core/esh_checker.sv]
module esh_checker
    import esh_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0] m_tuser
);

    // A result waiting on the master side stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_READ_DONE) && (m_tdata[47:42] == 6'd0))
        else $error("bad status code or fill bits");

    // A counted bin lies above channel zero and holds at least the beat just counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_COUNTED) |-> (m_tdata[9:0] != 10'd0) && (m_tdata[41:10] != 32'd0))
        else $error("counted result with zero bin or count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == ST_IGNORED) || (m_tuser == ST_BAD_ADDR)) |-> (m_tdata == 48'd0))
        else $error("rejected result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_RANGE) |-> (m_tdata[41:10] == 32'd0))
        else $error("out of range result carries a count");

endmodule

bind energy_spectrum_histogrammer esh_checker u_esh_checker (
    .clk(clk),
    .rst_n(rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);

[tb/energy_spectrum_histogrammer_test.sv]
`timescale 1ns / 1ps

module energy_spectrum_histogrammer_test;
    import esh_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PHASE_BEATS = 240;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed
    {
        logic [1:0] func;
        logic [3:0] det;
        logic [23:0] energy;
        logic [1:0] cry;
        logic [9:0] bidx;
    } beat_t;

    typedef struct packed
    {
        logic [2:0] status;
        logic [9:0] bin;
        logic [31:0] count;
    } outcome_t;

    typedef struct packed
    {
        bit is_cfg;
        logic [1:0] reg_idx;
        logic [31:0] reg_val;
        beat_t beat;
        bit known;
        outcome_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;   // detector[3:0], energy[27:4], crystal[29:28], bin_index[39:30]
    logic [1:0] s_tuser = '0;    // func[1:0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;        // bin_out[9:0], count[41:10], zero fill[47:42]
    logic [2:0] m_tuser;         // status[2:0]

    energy_spectrum_histogrammer dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted histogram contents and register copies.
    logic [31:0] spectrum_bins [0:32767];
    logic [23:0] cfg_e_high = 24'hFFFFFF;
    logic [23:0] cfg_bin_width = 24'd16384;
    logic [9:0] cfg_num_channels = 10'd1023;

    outcome_t pending_results [$];
    outcome_t oldest;
    int errors = 0;
    int idle_cycles = 0;
    int n_beats = 0;
    int n_counted = 0;
    int n_reads = 0;
    int n_rejected = 0;
    int n_settings = 0;

    // Sender and receiver pacing.
    bit valid_on = 1'b0;
    bit gaps_on = 1'b1;
    bit no_gaps = 1'b0;
    int burst_left = 0;
    int ready_mode = 1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_cycle = 0;

    function automatic outcome_t histogram_outcome(input beat_t b);
        outcome_t o;
        logic [23:0] w;
        logic [23:0] q;
        logic [9:0] ch;
        logic [14:0] idx;
        o = '0;
        if (b.func == FUNC_UNUSED)
            o.status = ST_IGNORED;
        else if (b.cry > 2'd1)
            o.status = ST_BAD_ADDR;
        else if (b.func == FUNC_RECORD)
        begin
            if (b.energy == 24'd0)
                o.status = ST_IGNORED;
            else if (b.energy > cfg_e_high)
                o.status = ST_RANGE;
            else
            begin
                w = (cfg_bin_width == 24'd0) ? 24'd1 : cfg_bin_width;
                q = (cfg_e_high - b.energy) / w;
                if (q >= {14'd0, cfg_num_channels})
                    o.status = ST_IGNORED;
                else
                begin
                    ch = cfg_num_channels - q[9:0];
                    idx = {b.det, b.cry[0], ch};
                    if (spectrum_bins[idx] != COUNT_MAX)
                        spectrum_bins[idx] = spectrum_bins[idx] + 32'd1;
                    o.status = ST_COUNTED;
                    o.bin = ch;
                    o.count = spectrum_bins[idx];
                end
            end
        end
        else
        begin
            idx = {b.det, b.cry[0], b.bidx};
            o.status = ST_READ_DONE;
            o.bin = b.bidx;
            o.count = spectrum_bins[idx];
            if (b.func == FUNC_READ_CLEAR)
                spectrum_bins[idx] = '0;
        end
        return o;
    endfunction

    function automatic step_row_t beat_row(input logic [1:0] func, input logic [3:0] det,
                                           input logic [23:0] energy, input logic [1:0] cry,
                                           input logic [9:0] bidx);
        step_row_t r;
        r = '0;
        r.beat = {func, det, energy, cry, bidx};
        return r;
    endfunction

    function automatic step_row_t known_row(input logic [1:0] func, input logic [3:0] det,
                                            input logic [23:0] energy, input logic [1:0] cry,
                                            input logic [9:0] bidx, input logic [2:0] status,
                                            input logic [9:0] bin, input logic [31:0] count);
        step_row_t r;
        r = beat_row(func, det, energy, cry, bidx);
        r.known = 1'b1;
        r.want = {status, bin, count};
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [1:0] idx, input logic [31:0] value);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    task automatic send_beat(input beat_t b, input bit known, input outcome_t want);
        outcome_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= {b.bidx, b.cry, b.energy, b.det};
        s_tuser <= b.func;
        valid_on = 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        predicted = histogram_outcome(b);
        pending_results.push_back(known ? want : predicted);
        n_beats++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (gaps_on && !no_gaps)
            begin
                // Long gaps now and then, so that pauses land at varied points of the divider's work.
                s_tvalid <= 1'b0;
                valid_on = 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 4))
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (valid_on)
        begin
            s_tvalid <= 1'b0;
            valid_on = 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_NUM_CHANNELS) ? 32'h3FF : 32'hFFFFFF;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_E_HIGH: cfg_e_high = value[23:0];
            REG_BIN_WIDTH: cfg_bin_width = value[23:0];
            default: cfg_num_channels = value[9:0];
        endcase
        // Read the register back.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            errors++;
            $display("%0t: register %0d readback expected %h actual %h", $time, idx,
                     value & mask, prdata & mask);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: checks results in order and paces m_tready.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: status %0d bin %0d count %0d", $time,
                         m_tuser, m_tdata[9:0], m_tdata[41:10]);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (m_tuser !== oldest.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, oldest.status,
                             m_tuser);
                end
                if (m_tdata[9:0] !== oldest.bin)
                begin
                    errors++;
                    $display("%0t: bin_out expected %0d actual %0d", $time, oldest.bin,
                             m_tdata[9:0]);
                end
                if (m_tdata[41:10] !== oldest.count)
                begin
                    errors++;
                    $display("%0t: count expected %0d actual %0d", $time, oldest.count,
                             m_tdata[41:10]);
                end
                case (oldest.status)
                    ST_COUNTED: n_counted++;
                    ST_READ_DONE: n_reads++;
                    default: n_rejected++;
                endcase
            end
        end

        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                2: m_tready <= ((rx_cycle % 7) >= 3);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("energy_spectrum_histogrammer_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        step_row_t directed_steps [$];
        step_row_t row;
        beat_t b;
        logic [3:0] hot_det [0:1];
        logic [9:0] hot_ch [0:3];
        logic [31:0] rnd;
        logic [23:0] new_e_high;
        logic [23:0] new_width;
        logic [9:0] new_channels;
        int unsigned w;
        int unsigned ch_t;
        longint span;
        longint e_try;
        int pick;

        for (int i = 0; i < 32768; i++)
            spectrum_bins[i] = '0;

        // Directed part, under the reset settings first.
        directed_steps.push_back(known_row(FUNC_READ, 4'd0, 24'd0, 2'd0, 10'd0,
                                           ST_READ_DONE, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_READ_CLEAR, 4'd15, 24'h123456, 2'd1, 10'd1023,
                                           ST_READ_DONE, 10'd1023, 32'd0));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd4, 24'd0, 2'd0, 10'd0,
                                           ST_IGNORED, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd0, 24'hFFFFFF, 2'd0, 10'd0,
                                           ST_COUNTED, 10'd1023, 32'd1));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd0, 24'hFFFFFF, 2'd0, 10'd5,
                                           ST_COUNTED, 10'd1023, 32'd2));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd0, 24'd1, 2'd0, 10'd0,
                                           ST_IGNORED, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd2, 24'h800000, 2'd2, 10'd0,
                                           ST_BAD_ADDR, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_READ, 4'd3, 24'd0, 2'd3, 10'd17,
                                           ST_BAD_ADDR, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_UNUSED, 4'd5, 24'hFFFFFF, 2'd0, 10'd9,
                                           ST_IGNORED, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_UNUSED, 4'd5, 24'd1, 2'd3, 10'd9,
                                           ST_IGNORED, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd0, 24'hFFBFFF, 2'd0, 10'd0,
                                           ST_COUNTED, 10'd1022, 32'd1));
        directed_steps.push_back(known_row(FUNC_READ, 4'd0, 24'd0, 2'd0, 10'd1023,
                                           ST_READ_DONE, 10'd1023, 32'd2));
        directed_steps.push_back(known_row(FUNC_READ_CLEAR, 4'd0, 24'd0, 2'd0, 10'd1023,
                                           ST_READ_DONE, 10'd1023, 32'd2));
        directed_steps.push_back(known_row(FUNC_READ, 4'd0, 24'd0, 2'd0, 10'd1023,
                                           ST_READ_DONE, 10'd1023, 32'd0));
        directed_steps.push_back(beat_row(FUNC_RECORD, 4'd15, 24'h800000, 2'd1, 10'd0));
        directed_steps.push_back(beat_row(FUNC_RECORD, 4'd7, 24'hABCDEF, 2'd0, 10'd0));
        directed_steps.push_back(beat_row(FUNC_READ, 4'd15, 24'd0, 2'd1, 10'd512));
        // Narrow spectrum with unit bins: the top edge and both ends of the channel range.
        directed_steps.push_back(cfg_row(REG_E_HIGH, 32'h100000));
        directed_steps.push_back(cfg_row(REG_BIN_WIDTH, 32'd1));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd1, 24'h100001, 2'd1, 10'd0,
                                           ST_RANGE, 10'd0, 32'd0));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd1, 24'h100000, 2'd1, 10'd0,
                                           ST_COUNTED, 10'd1023, 32'd1));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd1, 24'h0FFC02, 2'd1, 10'd0,
                                           ST_COUNTED, 10'd1, 32'd1));
        directed_steps.push_back(known_row(FUNC_RECORD, 4'd1, 24'h0FFC01, 2'd1, 10'd0,
                                           ST_IGNORED, 10'd0, 32'd0));
        // A zero bin width acts as a width of one.
        directed_steps.push_back(cfg_row(REG_BIN_WIDTH, 32'd0));
        directed_steps.push_back(beat_row(FUNC_RECORD, 4'd1, 24'h0FFFFB, 2'd1, 10'd0));
        directed_steps.push_back(beat_row(FUNC_READ_CLEAR, 4'd1, 24'd0, 2'd1, 10'd1018));

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            row = directed_steps[i];
            if (row.is_cfg)
            begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                send_beat(row.beat, row.known, row.want);
        end
        n_settings = 3;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    new_e_high = 24'hFFFFFF;
                    new_width = 24'd1;
                    new_channels = 10'd1023;
                end
                1:
                begin
                    new_e_high = 24'd0;
                    new_width = 24'hFFFFFF;
                    new_channels = 10'd1;
                end
                2:
                begin
                    rnd = $urandom();
                    new_e_high = $urandom_range(24'hFFFFFF, 1000);
                    new_width = $urandom_range(4096, 1);
                    new_channels = $urandom_range(1023, 1);
                end
                3:
                begin
                    rnd = $urandom();
                    new_e_high = rnd[23:0];
                    new_width = 24'd0;
                    new_channels = 10'd1023;
                end
                4:
                begin
                    new_e_high = 24'hFFFFFF;
                    new_width = 24'hFFFFFF;
                    new_channels = 10'd1023;
                end
                default:
                begin
                    rnd = $urandom();
                    new_e_high = rnd[23:0];
                    new_width = $urandom_range(65535, 1);
                    new_channels = $urandom_range(1023, 1);
                end
            endcase

            // The sender waits here until every outstanding result has come back.
            drain_results();
            write_reg(REG_E_HIGH, {8'd0, new_e_high});
            write_reg(REG_BIN_WIDTH, {8'd0, new_width});
            write_reg(REG_NUM_CHANNELS, {22'd0, new_channels});
            n_settings++;

            ready_mode = (phase == 0) ? 0 : $urandom_range(0, 3);
            gaps_on = (phase != 0);
            for (int k = 0; k < 2; k++)
            begin
                rnd = $urandom();
                hot_det[k] = rnd[3:0];
            end
            for (int k = 0; k < 4; k++)
                hot_ch[k] = $urandom_range(cfg_num_channels, 1);

            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (phase == 2 && i == 60)
                begin
                    hold_req = 1'b1;
                    no_gaps = 1'b1;
                end
                if (phase == 2 && i == 120)
                    no_gaps = 1'b0;

                rnd = $urandom();
                pick = $urandom_range(0, 99);
                b.det = ($urandom_range(0, 3) == 0) ? rnd[3:0] : hot_det[rnd[4]];
                b.cry = {1'b0, rnd[5]};
                b.bidx = rnd[15:6];
                b.energy = '0;
                if (pick < 55)
                begin
                    // Record aimed at a chosen channel, mostly a few hot ones.
                    b.func = FUNC_RECORD;
                    w = (cfg_bin_width == 24'd0) ? 1 : cfg_bin_width;
                    ch_t = ($urandom_range(0, 2) == 0) ? $urandom_range(cfg_num_channels, 1)
                                                       : hot_ch[$urandom_range(0, 3)];
                    if (ch_t > cfg_num_channels || ch_t == 0)
                        ch_t = cfg_num_channels;
                    span = longint'(cfg_num_channels - ch_t) * w + $urandom_range(w - 1, 0);
                    e_try = longint'(cfg_e_high) - span;
                    if (e_try < 1)
                        e_try = (cfg_e_high == 24'd0) ? 1 : $urandom_range(cfg_e_high, 1);
                    b.energy = e_try[23:0];
                end
                else if (pick < 75)
                begin
                    b.func = ($urandom_range(0, 3) == 0) ? FUNC_READ_CLEAR : FUNC_READ;
                    if (rnd[16])
                        b.bidx = hot_ch[rnd[18:17]];
                end
                else if (pick < 85)
                begin
                    b.func = FUNC_RECORD;
                    rnd = $urandom();
                    b.energy = rnd[23:0];
                end
                else
                begin
                    b.func = rnd[17:16];
                    b.cry = rnd[19:18];
                    rnd = $urandom();
                    b.energy = rnd[23:0];
                    b.det = rnd[27:24];
                end
                send_beat(b, 1'b0, '0);
            end
        end

        drain_results();
        repeat (40)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Sent %0d beats under %0d register settings, with sender gaps, stalls",
                 n_beats, n_settings);
        $display("and a long output hold; %0d counted, %0d read, %0d rejected or ignored.",
                 n_counted, n_reads, n_rejected);
        if (errors == 0)
            $display("energy_spectrum_histogrammer_test: done, clean");
        else
            $display("energy_spectrum_histogrammer_test: done, errors");
        $finish;
    end

endmodule

[energy_spectrum_histogrammer.f]
rtl/core/esh_pkg.sv
rtl/core/esh_front.sv
rtl/core/esh_queue.sv
rtl/core/esh_back.sv
rtl/core/energy_spectrum_histogrammer.sv
rtl/core/esh_checker.sv
tb/energy_spectrum_histogrammer_test.sv
